// ===== hdl/skstore_pkg.sv =====
package skstore_pkg;

    localparam int CAPACITY   = 8;
    localparam int KEY_WIDTH  = 32;
    localparam int ITEM_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);

    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_APPEND   = 3'd2;
    localparam logic [2:0] ACT_PREPEND  = 3'd3;
    localparam logic [2:0] ACT_RM_FIRST = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
    localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [2:0]                  action;
        logic signed [KEY_WIDTH-1:0] key;
        logic [ITEM_WIDTH-1:0]       item;
    } t_req;

    typedef struct packed {
        logic [2:0]                  status;
        logic [ITEM_WIDTH-1:0]       item_out;
        logic signed [KEY_WIDTH-1:0] key_out;
        logic [CNT_W-1:0]            occupancy;
    } t_rsp;

    typedef struct packed {
        logic signed [KEY_WIDTH-1:0] key;
        logic [ITEM_WIDTH-1:0]       item;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic                        ins_en;
        logic                        rm_en;
        logic                        sort_mode;
        logic                        pre_mode;
        logic                        rm_first;
        logic signed [KEY_WIDTH-1:0] key;
        t_entry                      new_entry;
    } t_ctrl;

    // handed from a cell to its right neighbor
    typedef struct packed {
        logic   occ;
        logic   shr;
        logic   seen;
        t_entry entry;
    } t_link;

endpackage

// ===== hdl/skstore_cell.sv =====
module skstore_cell (
    input  logic                  i_clk,
    input  logic                  i_occ,
    input  skstore_pkg::t_ctrl    i_ctrl,
    input  skstore_pkg::t_link    i_left,
    input  skstore_pkg::t_entry   i_right,
    output skstore_pkg::t_link    o_link,
    output logic                  o_hit
);
    import skstore_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   lt;
    logic   shr;
    logic   hit;
    logic   seen;
    logic   at_end;

    always_comb begin
        lt     = i_ctrl.key < r_entry.key;
        shr    = i_occ && ((i_ctrl.sort_mode && lt) || i_ctrl.pre_mode);
        hit    = i_occ && (i_ctrl.rm_first || (i_ctrl.key == r_entry.key));
        seen   = i_left.seen || hit;
        at_end = i_left.occ && !i_occ;

        n_entry = r_entry;
        if (i_ctrl.ins_en) begin
            // make room: entries past the slot move one cell right
            if (i_left.shr) begin
                n_entry = i_left.entry;
            end else if (shr || at_end) begin
                n_entry = i_ctrl.new_entry;
            end
        end else if (i_ctrl.rm_en && seen) begin
            // close the gap behind the removed entry
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link = '{occ: i_occ, shr: shr, seen: seen, entry: r_entry};
    assign o_hit  = hit && !i_left.seen;

endmodule

// ===== hdl/sorted_key_store_core.sv =====
// Sorted key store: up to CAPACITY (key, item) entries kept in ascending key order.
// Request channel: i_in_valid / o_in_stall with payload i_in_req (action, key, item).
// Actions: sorted insert (after equal keys), remove by key (first match), append
// (last key + 1), prepend (first key - 1), remove first. Append or prepend on an
// empty store uses key 0.
// Response channel: o_out_valid / i_out_stall with payload o_out_rsp (status,
// item_out, key_out, occupancy). Exactly one response per request.
// Latency: the response appears the cycle after the request is taken.
// Throughput: one request per cycle unless stalled. Each entry sits in one cell of a
// chain; all cells compare against the broadcast key and shift toward a neighbor in
// the same cycle, so the ripple through the chain of cells sets the cycle time.
// Reset empties the store (occupancy 0) and drops any pending response; the entry
// contents are not cleared.
// While the receiver stalls, the response holds and o_in_stall is raised, so no
// new request is taken until the held response leaves.
module sorted_key_store_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  skstore_pkg::t_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output skstore_pkg::t_rsp  o_out_rsp
);
    import skstore_pkg::*;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    t_rsp               r_rsp;
    t_rsp               n_rsp;
    logic               accept;
    t_ctrl              ctrl;
    t_link              links [CAPACITY+1];
    t_entry             rights [CAPACITY];
    logic [CAPACITY-1:0] hits;
    logic               full;
    logic               empty;
    logic               found;
    t_entry             hit_entry;
    logic signed [KEY_WIDTH-1:0] last_key;
    logic signed [KEY_WIDTH-1:0] first_key;
    logic [IDX_W-1:0]   last_idx;
    logic [CNT_W-1:0]   last_cnt;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    assign links[0] = '{occ: 1'b1, shr: 1'b0, seen: 1'b0, entry: '0};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_tail
            assign rights[g] = '0;
        end else begin : g_mid
            assign rights[g] = links[g+2].entry;
        end

        skstore_cell u_cell (
            .i_clk   (i_clk),
            .i_occ   (r_count > CNT_W'(g)),
            .i_ctrl  (ctrl),
            .i_left  (links[g]),
            .i_right (rights[g]),
            .o_link  (links[g+1]),
            .o_hit   (hits[g])
        );
    end

    always_comb begin
        full      = r_count == CNT_W'(CAPACITY);
        empty     = r_count == '0;
        found     = |hits;
        last_cnt  = r_count - 1'b1;
        last_idx  = last_cnt[IDX_W-1:0];
        last_key  = links[32'(last_idx) + 1].entry.key;
        first_key = links[1].entry.key;
        hit_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hits[i]) begin
                hit_entry = hit_entry | links[i+1].entry;
            end
        end

        ctrl                = '0;
        ctrl.key            = i_in_req.key;
        ctrl.new_entry.item = i_in_req.item;
        n_rsp               = '0;
        n_rsp.status        = ST_NOTFOUND;

        case (i_in_req.action)
            ACT_INSERT: begin
                ctrl.sort_mode = 1'b1;
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status       = ST_OK;
                    n_rsp.key_out      = i_in_req.key;
                    ctrl.new_entry.key = i_in_req.key;
                    ctrl.ins_en        = 1'b1;
                end
            end
            ACT_APPEND: begin
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else if (!empty && last_key == KEY_MAX) begin
                    n_rsp.status = ST_OVERFLOW;
                end else begin
                    n_rsp.status       = ST_OK;
                    ctrl.new_entry.key = empty ? '0 : last_key + 1'b1;
                    n_rsp.key_out      = ctrl.new_entry.key;
                    ctrl.ins_en        = 1'b1;
                end
            end
            ACT_PREPEND: begin
                ctrl.pre_mode = 1'b1;
                if (full) begin
                    n_rsp.status = ST_FULL;
                end else if (!empty && first_key == KEY_MIN) begin
                    n_rsp.status = ST_OVERFLOW;
                end else begin
                    n_rsp.status       = ST_OK;
                    ctrl.new_entry.key = empty ? '0 : first_key - 1'b1;
                    n_rsp.key_out      = ctrl.new_entry.key;
                    ctrl.ins_en        = 1'b1;
                end
            end
            ACT_REMOVE, ACT_RM_FIRST: begin
                ctrl.rm_first = i_in_req.action == ACT_RM_FIRST;
                if (empty) begin
                    n_rsp.status = ST_EMPTY;
                end else if (found) begin
                    n_rsp.status   = ST_OK;
                    n_rsp.item_out = hit_entry.item;
                    n_rsp.key_out  = hit_entry.key;
                    ctrl.rm_en     = 1'b1;
                end
            end
            default: begin
                n_rsp.status = ST_NOTFOUND;
            end
        endcase

        // gate the cell updates with the handshake
        ctrl.ins_en = ctrl.ins_en && accept;
        ctrl.rm_en  = ctrl.rm_en && accept;

        n_count = r_count;
        if (ctrl.ins_en) begin
            n_count = r_count + 1'b1;
        end else if (ctrl.rm_en) begin
            n_count = r_count - 1'b1;
        end
        n_rsp.occupancy = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hits))
        else $error("more than one cell claims the removal");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_count == $past(n_count))
        else $error("occupancy does not follow the accepted request");

    a_rsp_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid && o_out_rsp.occupancy == r_count)
        else $error("response occupancy differs from the store");
`endif

endmodule
